// ===== hdl/lcdx_pkg.sv =====
// shared types and constants of the character lcd expander writer
package lcdx_pkg;

  typedef enum logic [1:0] {
    CmdInstr  = 2'd0,
    CmdChar   = 2'd1,
    CmdLight  = 2'd2,
    CmdNumber = 2'd3
  } cmd_e;

  localparam logic [3:0] FmtDigit = 4'd0;
  localparam logic [3:0] FmtU2    = 4'd1;
  localparam logic [3:0] FmtU3    = 4'd2;
  localparam logic [3:0] FmtS3    = 4'd3;
  localparam logic [3:0] FmtU4    = 4'd4;
  localparam logic [3:0] FmtS4    = 4'd5;
  localparam logic [3:0] FmtU5    = 4'd6;
  localparam logic [3:0] FmtS6    = 4'd7;
  localparam logic [3:0] FmtFix31 = 4'd8;
  localparam logic [3:0] FmtFix22 = 4'd9;
  localparam logic [3:0] FmtFix41 = 4'd10;
  localparam logic [3:0] FmtFix32 = 4'd11;

  localparam int MaxChars = 6;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;

  // one queued transaction: either a run of characters or a single raw port byte
  typedef struct packed {
    logic [6:0]                addr;
    logic                      light;
    logic                      raw;
    logic                      rs;
    logic [2:0]                count;
    logic [MaxChars-1:0][7:0]  chars;
  } job_t;

endpackage

// ===== hdl/lcdx_front.sv =====
// front end: accepts commands, extracts decimal digits, builds character jobs
module lcdx_front import lcdx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] command_i,
  input  logic [7:0] byte_value_i,
  input  logic signed [15:0] number_i,
  input  logic [3:0] number_format_i,
  input  logic [6:0] addr_i,
  output logic       job_push_o,
  output job_t       job_o,
  input  logic       job_full_i
);

  localparam int Stages = 5;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  bval;
    logic [3:0]  fmt;
    logic        neg;
    logic [6:0]  addr;
    logic        light;
    logic [15:0] rem;
    logic [4:0][3:0] dig;
  } fr_t;

  // largest k with k*w <= r
  function automatic logic [3:0] place_digit(logic [15:0] r, logic [15:0] w);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, r} >= 20'(k) * {4'd0, w}) d = 4'(k);
    end
    return d;
  endfunction

  logic [Stages-1:0] vld_q, vld_d;
  fr_t fr_q [Stages];
  fr_t fr_d [Stages];
  logic light_q, light_d;
  logic stall, accept, signed_fmt, light_new;
  logic [15:0] mag;
  logic [3:0] ge;
  logic [7:0] ls [5];

  assign job_push_o = vld_q[Stages-1] && (job_o.count != 3'd0);
  assign stall  = job_push_o && job_full_i;
  assign full_o = stall;
  assign accept = push_i && !full_o;

  always_comb begin
    signed_fmt = !(number_format_i == FmtDigit || number_format_i == FmtU2 ||
                   number_format_i == FmtU3 || number_format_i == FmtU4 ||
                   number_format_i == FmtU5);
    if (number_format_i == FmtDigit) begin
      mag = {8'd0, byte_value_i};
    end else if (number_i[15]) begin
      mag = signed_fmt ? 16'(-number_i) : 16'd0;
    end else begin
      mag = 16'(number_i);
    end
    light_new = (cmd_e'(command_i) == CmdLight) ? (byte_value_i != 8'd0) : light_q;
    light_d = accept ? light_new : light_q;
  end

  always_comb begin
    vld_d = vld_q;
    for (int s = 0; s < Stages; s++) fr_d[s] = fr_q[s];
    if (!stall) begin
      vld_d = {vld_q[Stages-2:0], accept};
      fr_d[0].cmd   = cmd_e'(command_i);
      fr_d[0].bval  = byte_value_i;
      fr_d[0].fmt   = number_format_i;
      fr_d[0].neg   = number_i[15];
      fr_d[0].addr  = addr_i;
      fr_d[0].light = light_new;
      fr_d[0].rem   = mag;
      fr_d[0].dig   = '0;
      fr_d[1] = fr_q[0];
      fr_d[1].dig[4] = place_digit(fr_q[0].rem, 16'd10000);
      fr_d[1].rem = 16'(fr_q[0].rem - 16'(fr_d[1].dig[4]) * 16'd10000);
      fr_d[2] = fr_q[1];
      fr_d[2].dig[3] = place_digit(fr_q[1].rem, 16'd1000);
      fr_d[2].rem = 16'(fr_q[1].rem - 16'(fr_d[2].dig[3]) * 16'd1000);
      fr_d[3] = fr_q[2];
      fr_d[3].dig[2] = place_digit(fr_q[2].rem, 16'd100);
      fr_d[3].rem = 16'(fr_q[2].rem - 16'(fr_d[3].dig[2]) * 16'd100);
      fr_d[4] = fr_q[3];
      fr_d[4].dig[1] = place_digit(fr_q[3].rem, 16'd10);
      fr_d[4].dig[0] = 4'(fr_q[3].rem - 16'(fr_d[4].dig[1]) * 16'd10);
      fr_d[4].rem = 16'd0;
    end
  end

  // character builder on the last stage
  always_comb begin
    fr_t f;
    f = fr_q[Stages-1];
    for (int k = 1; k < 5; k++) begin
      ge[k-1] = 1'b0;
      for (int j = k; j < 5; j++) if (f.dig[j] != 4'd0) ge[k-1] = 1'b1;
    end
    ls[0] = ChZero | {4'd0, f.dig[0]};
    for (int k = 1; k < 5; k++) ls[k] = ge[k-1] ? (ChZero | {4'd0, f.dig[k]}) : ChSpace;
    job_o.addr  = f.addr;
    job_o.light = f.light;
    job_o.raw   = 1'b0;
    job_o.rs    = 1'b1;
    job_o.count = 3'd0;
    job_o.chars = {MaxChars{ChSpace}};
    case (f.cmd)
      CmdInstr, CmdChar: begin
        job_o.rs = (f.cmd == CmdChar);
        job_o.count = 3'd1;
        job_o.chars[0] = f.bval;
      end
      CmdLight: begin
        job_o.raw = 1'b1;
        job_o.count = 3'd1;
        job_o.chars[0] = {4'd0, f.light, 3'd0};
      end
      default: begin
        case (f.fmt)
          FmtDigit: begin
            job_o.count = 3'd1; job_o.chars[0] = ls[0];
          end
          FmtU2: begin
            job_o.count = 3'd2; job_o.chars[0] = ls[1]; job_o.chars[1] = ls[0];
          end
          FmtU3: begin
            job_o.count = 3'd3;
            job_o.chars[0] = ls[2]; job_o.chars[1] = ls[1]; job_o.chars[2] = ls[0];
          end
          FmtU4: begin
            job_o.count = 3'd4;
            job_o.chars[0] = ls[3]; job_o.chars[1] = ls[2];
            job_o.chars[2] = ls[1]; job_o.chars[3] = ls[0];
          end
          FmtU5: begin
            job_o.count = 3'd5;
            job_o.chars[0] = ls[4]; job_o.chars[1] = ls[3]; job_o.chars[2] = ls[2];
            job_o.chars[3] = ls[1]; job_o.chars[4] = ls[0];
          end
          FmtS3: begin
            job_o.count = 3'd3;
            job_o.chars[0] = f.neg ? ChMinus : ls[2];
            job_o.chars[1] = ls[1]; job_o.chars[2] = ls[0];
          end
          FmtS4: begin
            job_o.count = 3'd4;
            job_o.chars[0] = f.neg ? ChMinus : ls[3];
            job_o.chars[1] = ls[2]; job_o.chars[2] = ls[1]; job_o.chars[3] = ls[0];
          end
          FmtS6: begin
            job_o.count = 3'd6;
            job_o.chars[0] = f.neg ? ChMinus : ChSpace;
            job_o.chars[1] = ls[4]; job_o.chars[2] = ls[3]; job_o.chars[3] = ls[2];
            job_o.chars[4] = ls[1]; job_o.chars[5] = ls[0];
          end
          FmtFix31: begin
            job_o.count = 3'd5;
            job_o.chars[0] = f.neg ? ChMinus : ls[3];
            job_o.chars[1] = ls[2];
            job_o.chars[2] = ChZero | {4'd0, f.dig[1]};
            job_o.chars[3] = ChComma; job_o.chars[4] = ls[0];
          end
          FmtFix22: begin
            job_o.count = 3'd5;
            job_o.chars[0] = f.neg ? ChMinus : ls[3];
            job_o.chars[1] = ChZero | {4'd0, f.dig[2]};
            job_o.chars[2] = ChComma;
            job_o.chars[3] = ChZero | {4'd0, f.dig[1]}; job_o.chars[4] = ls[0];
          end
          FmtFix41: begin
            job_o.count = 3'd6;
            job_o.chars[0] = f.neg ? ChMinus : ls[4];
            job_o.chars[1] = ls[3]; job_o.chars[2] = ls[2];
            job_o.chars[3] = ChZero | {4'd0, f.dig[1]};
            job_o.chars[4] = ChComma; job_o.chars[5] = ls[0];
          end
          FmtFix32: begin
            job_o.count = 3'd6;
            job_o.chars[0] = f.neg ? ChMinus : ls[4];
            job_o.chars[1] = ls[3];
            job_o.chars[2] = ChZero | {4'd0, f.dig[2]};
            job_o.chars[3] = ChComma;
            job_o.chars[4] = ChZero | {4'd0, f.dig[1]}; job_o.chars[5] = ls[0];
          end
          default: job_o.count = 3'd0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      light_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      light_q <= light_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Stages; s++) fr_q[s] <= fr_d[s];
  end

endmodule

// ===== hdl/lcdx_fifo.sv =====
// short job queue between front and back
module lcdx_fifo import lcdx_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= bump(wr_q);
      if (do_pop)  rd_q <= bump(rd_q);
      cnt_q <= CntW'(cnt_q + CntW'(do_push) - CntW'(do_pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== hdl/lcdx_back.sv =====
// back end: turns queued jobs into expander port bytes, one beat per cycle while the receiver pops
module lcdx_back import lcdx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] bus_address_o,
  output logic [7:0] expander_byte_o,
  output logic       last_o
);

  logic [2:0] idx_q, idx_d;
  logic [1:0] ph_q, ph_d;
  logic       ovld_q, ovld_d;
  logic       adv, fin;
  logic [7:0] ch, byte_d;
  logic [3:0] nib;

  assign adv = job_valid_i && (!ovld_q || pop);

  always_comb begin
    ch  = job_i.chars[idx_q];
    nib = ph_q[1] ? ch[3:0] : ch[7:4];
    if (job_i.raw) begin
      byte_d = job_i.chars[0];
      fin    = 1'b1;
    end else begin
      // e high on the first beat of each nibble
      byte_d = {nib, job_i.light, !ph_q[0], 1'b0, job_i.rs};
      fin    = (idx_q == 3'(job_i.count - 3'd1)) && (ph_q == 2'd3);
    end
    job_pop_o = adv && fin;
    idx_d = idx_q;
    ph_d  = ph_q;
    if (adv) begin
      if (fin) begin
        idx_d = 3'd0;
        ph_d  = 2'd0;
      end else begin
        ph_d = 2'(ph_q + 2'd1);
        if (ph_q == 2'd3) idx_d = 3'(idx_q + 3'd1);
      end
    end
    ovld_d = adv ? 1'b1 : (pop ? 1'b0 : ovld_q);
  end

  assign empty = !ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 3'd0;
      ph_q   <= 2'd0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ph_q   <= ph_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bus_address_o   <= job_i.addr;
      expander_byte_o <= byte_d;
      last_o          <= fin;
    end
  end

endmodule

// ===== hdl/char_lcd_expander_number_writer_unit.sv =====
// an accepted command passes the front-end pipeline, job queue and back-end
// output register; one command per cycle is taken while full is low, bytes
// leave one per cycle while the receiver pops, and a command yields 1 byte
// (backlight), 4 (instruction or character) or 4 per number character, up to 24
// reset: backlight off, expander address 32, job queue and pipeline empty
module char_lcd_expander_number_writer_unit import lcdx_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  byte_value_i,
  input  logic signed [15:0] number_i,
  input  logic [3:0]  number_format_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  bus_address_o,
  output logic [7:0]  expander_byte_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] addr_q;
  logic       job_push, job_full, job_valid, job_pop;
  job_t       job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, addr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 7'd32;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      addr_q <= pwdata[6:0];
    end
  end

  lcdx_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .command_i, .byte_value_i,
    .number_i, .number_format_i, .addr_i(addr_q), .job_push_o(job_push),
    .job_o(job_in), .job_full_i(job_full)
  );

  lcdx_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(job_push), .job_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .job_o(job_out), .valid_o(job_valid)
  );

  lcdx_back u_back (
    .clk_i, .rst_ni, .job_i(job_out), .job_valid_i(job_valid), .job_pop_o(job_pop),
    .empty, .pop, .bus_address_o, .expander_byte_o, .last_o
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("waiting beat dropped");
  a_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !expander_byte_o[1]) else $error("rw bit set");
  a_e_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && expander_byte_o[2] |-> !last_o) else $error("e high on last beat");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for the character lcd expander number writer: random commands checked against a predictor
`timescale 1ns / 1ps

module tb;
  import lcdx_pkg::*;

  typedef struct packed {
    logic [6:0] addr;
    logic [7:0] pbyte;
    logic       fin;
  } port_beat_t;

  localparam logic [2:0] AddrExpander = 3'd0;
  localparam int CycleLimit = 400000;

  // expected port bytes and the predictor state they come from
  class port_byte_board;
    port_beat_t pending[$];
    logic [6:0] exp_addr;
    logic       light;
    int         errors;

    function new();
      exp_addr = 7'd32;
      light = 1'b0;
      errors = 0;
    endfunction

    function void put_beat(logic [7:0] b);
      port_beat_t e;
      e.addr = exp_addr;
      e.pbyte = b;
      e.fin = 1'b0;
      pending.push_back(e);
    endfunction

    function void put_nibbles(logic [7:0] v, logic rs);
      logic [7:0] hi, lo, lt;
      hi = v & 8'hF0;
      lo = {v[3:0], 4'h0};
      lt = {4'h0, light, 3'b000};
      put_beat(hi | lt | 8'h4 | rs);
      put_beat(hi | lt | rs);
      put_beat(lo | lt | 8'h4 | rs);
      put_beat(lo | lt | rs);
    endfunction

    function void put_char(logic [7:0] c);
      put_nibbles(c, 1'b1);
    endfunction

    function void put_digit(int unsigned d);
      put_char(ChZero + 8'(d % 10));
    endfunction

    function void lead(int unsigned m, int unsigned w);
      if (m >= w) put_digit((m % (w * 10)) / w);
      else put_char(ChSpace);
    endfunction

    function int unsigned sign_lead(int v, int unsigned w);
      if (v >= int'(w)) begin
        put_digit((int'(v) % (w * 10)) / w);
        return v;
      end
      if (v < 0) begin
        put_char(ChMinus);
        return -v;
      end
      put_char(ChSpace);
      return v;
    endfunction

    function void note_command(cmd_e cmd, logic [7:0] bv, logic signed [15:0] num,
                               logic [3:0] fmt);
      int v;
      int unsigned m;
      int n0;
      v = num;
      m = (v < 0) ? 0 : v;
      n0 = pending.size();
      case (cmd)
        CmdInstr: put_nibbles(bv, 1'b0);
        CmdChar: put_nibbles(bv, 1'b1);
        CmdLight: begin
          light = (bv != 0);
          put_beat({4'h0, light, 3'b000});
        end
        default: begin
          case (fmt)
            FmtDigit: put_digit(bv % 10);
            FmtU2: begin lead(m, 10); put_digit(m); end
            FmtU3: begin lead(m, 100); lead(m, 10); put_digit(m); end
            FmtU4: begin lead(m, 1000); lead(m, 100); lead(m, 10); put_digit(m); end
            FmtU5: begin
              lead(m, 10000); lead(m, 1000); lead(m, 100); lead(m, 10); put_digit(m);
            end
            FmtS3: begin m = sign_lead(v, 100); lead(m, 10); put_digit(m); end
            FmtS4: begin m = sign_lead(v, 1000); lead(m, 100); lead(m, 10); put_digit(m); end
            FmtS6: begin
              if (v < 0) begin put_char(ChMinus); m = -v; end
              else begin put_char(ChSpace); m = v; end
              lead(m, 10000); lead(m, 1000); lead(m, 100); lead(m, 10); put_digit(m);
            end
            FmtFix31: begin
              m = sign_lead(v, 1000); lead(m, 100);
              put_digit((m % 100) / 10); put_char(ChComma); put_digit(m);
            end
            FmtFix22: begin
              m = sign_lead(v, 1000); put_digit((m % 1000) / 100);
              put_char(ChComma); put_digit((m % 100) / 10); put_digit(m);
            end
            FmtFix41: begin
              m = sign_lead(v, 10000); lead(m, 1000); lead(m, 100);
              put_digit((m % 100) / 10); put_char(ChComma); put_digit(m);
            end
            FmtFix32: begin
              m = sign_lead(v, 10000); lead(m, 1000);
              put_digit((m % 1000) / 100); put_char(ChComma);
              put_digit((m % 100) / 10); put_digit(m);
            end
            default: ;
          endcase
        end
      endcase
      if (pending.size() > n0) pending[pending.size() - 1].fin = 1'b1;
    endfunction

    function void check_beat(port_beat_t got);
      port_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat addr=%h byte=%h last=%b", $time, got.addr,
                 got.pbyte, got.fin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.addr != e.addr) begin
        $display("%0t: bus_address expected %h actual %h", $time, e.addr, got.addr);
        errors++;
      end
      if (got.pbyte != e.pbyte) begin
        $display("%0t: expander_byte expected %h actual %h", $time, e.pbyte, got.pbyte);
        errors++;
      end
      if (got.fin != e.fin) begin
        $display("%0t: last expected %b actual %b", $time, e.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] command_i = '0;
  logic [7:0] byte_value_i = '0;
  logic signed [15:0] number_i = '0;
  logic [3:0] number_format_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [6:0] bus_address_o;
  logic [7:0] expander_byte_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  port_byte_board board = new();
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  char_lcd_expander_number_writer_unit dut (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample results at the rising edge
  always @(posedge clk_i) begin
    port_beat_t b;
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) begin
      b.addr = bus_address_o;
      b.pbyte = expander_byte_o;
      b.fin = last_o;
      board.check_beat(b);
    end
  end

  // receiver stalls
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_address(logic [6:0] a);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrExpander; pwdata <= {25'h0, a};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.exp_addr = a;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_command(cmd_e cmd, logic [7:0] bv, logic signed [15:0] num,
                              logic [3:0] fmt);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd; byte_value_i <= bv; number_i <= num; number_format_i <= fmt;
    do @(posedge clk_i); while (full);
    board.note_command(cmd, bv, num, fmt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_number();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 99));
      1: return -$signed(16'($urandom_range(0, 999)));
      2: return 16'($urandom_range(0, 99999));
      3: return 16'($urandom);
      4: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  task automatic random_phase(int n);
    cmd_e c;
    repeat (n) begin
      c = cmd_e'($urandom_range(0, 3));
      send_command(c, (c == CmdLight && $urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
                   pick_number(),
                   ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11)));
    end
  endtask

  initial begin
    logic signed [15:0] dv[7];
    dv = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd999, -16'sd99, 16'sd12345};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: instructions, characters, backlight, every format and an unknown one at edge values
    send_command(CmdInstr, 8'h00, 16'sd0, FmtDigit);
    send_command(CmdChar, 8'hFF, 16'sd0, FmtDigit);
    send_command(CmdLight, 8'h01, 16'sd0, FmtDigit);
    send_command(CmdInstr, 8'hA5, 16'sd0, FmtDigit);
    send_command(CmdNumber, 8'hFF, 16'sh8000, FmtDigit);
    for (int f = 1; f < 12; f++) send_command(CmdNumber, 8'h00, dv[f % 7], 4'(f));
    send_command(CmdNumber, 8'h5A, 16'sh8000, FmtS6);
    send_command(CmdNumber, 8'h00, -16'sd1234, FmtFix32);
    send_command(CmdNumber, 8'h00, 16'sd5, 4'd15);
    send_command(CmdLight, 8'h00, 16'sd0, FmtDigit);
    send_command(CmdChar, 8'h5A, 16'sd0, FmtDigit);
    drain();
    write_address(7'h7F);
    random_phase(70);
    drain();
    write_address(7'h00);
    random_phase(70);
    drain();
    write_address(7'($urandom));
    random_phase(70);
    drain();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
